// ----- rtl/tbc_pkg.sv -----
// Shared constants and types of the nine-node bilinear touch calibrator.
package tbc_pkg;

   localparam int ADC_BITS      = 12;
   localparam int FRACTION_BITS = 16;
   localparam int DIV_STEPS     = 4;
   localparam int QUOT_BITS     =
      ((ADC_BITS + FRACTION_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
   localparam int DIV_STAGES    = QUOT_BITS / DIV_STEPS;

   localparam int SIZE_BITS  = 10;
   localparam int COORD_BITS = 13;
   localparam int NODE_COUNT = 9;
   localparam int NODE_BITS  = 4;

   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(320);
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(480);
   localparam int EDGE_INSET = 15;
   localparam logic [COORD_BITS-1:0] MAX_X_SIXTEENTHS = COORD_BITS'(319 * 16);
   localparam logic [COORD_BITS-1:0] MAX_Y_SIXTEENTHS = COORD_BITS'(479 * 16);

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic ACTION_RECORD = 1'b0;
   localparam logic ACTION_MAP    = 1'b1;

endpackage

// ----- rtl/tbc_divider.sv -----
// Pipelined restoring divider giving the magnitude of num with fraction bits over den.
module tbc_divider
   import tbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 enable,
   input  logic [ADC_BITS-1:0]  num_in,
   input  logic [ADC_BITS-1:0]  den_in,
   output logic [QUOT_BITS-1:0] quot_out
);

   logic [ADC_BITS-1:0]  rem_ff [DIV_STAGES];
   logic [QUOT_BITS-1:0] dvd_ff [DIV_STAGES];
   logic [QUOT_BITS-1:0] quo_ff [DIV_STAGES];
   logic [ADC_BITS-1:0]  den_ff [DIV_STAGES];

   logic [ADC_BITS-1:0]  rem_in [DIV_STAGES];
   logic [QUOT_BITS-1:0] dvd_in [DIV_STAGES];
   logic [QUOT_BITS-1:0] quo_in [DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         logic [ADC_BITS-1:0]  rem_src;
         logic [QUOT_BITS-1:0] dvd_src;
         logic [QUOT_BITS-1:0] quo_src;
         logic [ADC_BITS-1:0]  den_src;

         if (k == 0) begin : g_first
            assign rem_src = '0;
            assign dvd_src = QUOT_BITS'({num_in, {FRACTION_BITS{1'b0}}});
            assign quo_src = '0;
            assign den_src = den_in;
         end else begin : g_next
            assign rem_src = rem_ff[k-1];
            assign dvd_src = dvd_ff[k-1];
            assign quo_src = quo_ff[k-1];
            assign den_src = den_ff[k-1];
         end

         always_comb begin
            logic [ADC_BITS:0]    trial;
            logic [ADC_BITS-1:0]  rem_v;
            logic [QUOT_BITS-1:0] dvd_v;
            logic [QUOT_BITS-1:0] quo_v;
            rem_v = rem_src;
            dvd_v = dvd_src;
            quo_v = quo_src;
            for (int i = 0; i < DIV_STEPS; i++) begin
               trial = {rem_v, dvd_v[QUOT_BITS-1]};
               dvd_v = {dvd_v[QUOT_BITS-2:0], 1'b0};
               if (trial >= {1'b0, den_src}) begin
                  trial = trial - {1'b0, den_src};
                  quo_v = {quo_v[QUOT_BITS-2:0], 1'b1};
               end else begin
                  quo_v = {quo_v[QUOT_BITS-2:0], 1'b0};
               end
               rem_v = trial[ADC_BITS-1:0];
            end
            rem_in[k] = rem_v;
            dvd_in[k] = dvd_v;
            quo_in[k] = quo_v;
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in[k];
               dvd_ff[k] <= dvd_in[k];
               quo_ff[k] <= quo_in[k];
               den_ff[k] <= den_src;
            end
         end
      end
   endgenerate

   assign quot_out = quo_ff[DIV_STAGES-1];

endmodule

// ----- rtl/touch_bilinear_calibrator_core.sv -----
// Top level of the nine-node bilinear touch calibrator: node table, cell choice and blend.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall action, node_index, raw_x, raw_y
//   rsp      out        rsp_valid/rsp_stall ok, screen_x_sixteenths, screen_y_sixteenths
//   csr      in         csr_write           csr_index, csr_data
//
// One request is taken per cycle while req_stall is low; a map request passes the operand
// registers, the DIV_STAGES stages of the pipelined dividers, the blend and response registers.
// Record requests update the node table at acceptance and leave a bubble in the pipeline.
// Reset clears the valid bits and restores the screen size; the node table is not cleared.
// A stalled response holds the whole pipeline, so req_stall follows rsp_stall while rsp_valid is high.
module touch_bilinear_calibrator_core
   import tbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [NODE_BITS-1:0]  req_node_index,
   input  logic [ADC_BITS-1:0]   req_raw_x,
   input  logic [ADC_BITS-1:0]   req_raw_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ok,
   output logic [COORD_BITS-1:0] rsp_screen_x_sixteenths,
   output logic [COORD_BITS-1:0] rsp_screen_y_sixteenths,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [SIZE_BITS-1:0]  csr_data
);

   localparam int TW = SIZE_BITS + 2;
   localparam int PW = QUOT_BITS + TW;
   localparam int SW = PW + FRACTION_BITS + 2;

   typedef struct packed {
      logic valid;
      logic ok;
      logic sign_x;
      logic sign_y;
      logic row;
      logic col;
   } side_type;

   typedef struct packed {
      logic          valid;
      logic          ok;
      logic          neg;
      logic [PW-1:0] prod;
      logic [TW-1:0] base;
   } blend_type;

   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [ADC_BITS-1:0]  node_x_ff [NODE_COUNT];
   logic [ADC_BITS-1:0]  node_y_ff [NODE_COUNT];

   logic advance, accept;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_data;
            CSR_SCREEN_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_action == ACTION_RECORD && req_node_index < NODE_BITS'(NODE_COUNT)) begin
         node_x_ff[req_node_index] <= req_raw_x;
         node_y_ff[req_node_index] <= req_raw_y;
      end
   end

   function automatic logic in_band(input logic [ADC_BITS-1:0] p,
                                    input logic [ADC_BITS-1:0] e0,
                                    input logic [ADC_BITS-1:0] e1);
      return (p >= e0 && p <= e1) || (p <= e0 && p >= e1);
   endfunction

   function automatic logic [ADC_BITS-1:0] max3(input logic [ADC_BITS-1:0] a,
                                                input logic [ADC_BITS-1:0] b,
                                                input logic [ADC_BITS-1:0] c);
      logic [ADC_BITS-1:0] m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

   // Cell choice and corner differences in the acceptance cycle.
   logic                row_sel, col_sel;
   logic [ADC_BITS-1:0] x00, x10, y00, y01;
   logic [ADC_BITS:0]   num_x, den_x, num_y, den_y;

   always_comb begin
      row_sel = !((req_raw_y < max3(node_y_ff[0], node_y_ff[1], node_y_ff[2]))
                  || in_band(req_raw_y, node_y_ff[0], node_y_ff[3]));
      col_sel = !((req_raw_x < max3(node_x_ff[0], node_x_ff[3], node_x_ff[6]))
                  || in_band(req_raw_x, node_x_ff[0], node_x_ff[1]));
      case ({row_sel, col_sel})
         2'b00: begin
            x00 = node_x_ff[0]; x10 = node_x_ff[1]; y00 = node_y_ff[0]; y01 = node_y_ff[3];
         end
         2'b01: begin
            x00 = node_x_ff[1]; x10 = node_x_ff[2]; y00 = node_y_ff[1]; y01 = node_y_ff[4];
         end
         2'b10: begin
            x00 = node_x_ff[3]; x10 = node_x_ff[4]; y00 = node_y_ff[3]; y01 = node_y_ff[6];
         end
         default: begin
            x00 = node_x_ff[4]; x10 = node_x_ff[5]; y00 = node_y_ff[4]; y01 = node_y_ff[7];
         end
      endcase
      num_x = {1'b0, req_raw_x} - {1'b0, x00};
      den_x = {1'b0, x10} - {1'b0, x00};
      num_y = {1'b0, req_raw_y} - {1'b0, y00};
      den_y = {1'b0, y01} - {1'b0, y00};
   end

   side_type            s1_ff;
   logic [ADC_BITS-1:0] nx_ff, dx_ff, ny_ff, dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (advance) begin
         s1_ff.valid  <= accept && req_action == ACTION_MAP;
         s1_ff.ok     <= den_x != '0 && den_y != '0;
         s1_ff.sign_x <= num_x[ADC_BITS] ^ den_x[ADC_BITS];
         s1_ff.sign_y <= num_y[ADC_BITS] ^ den_y[ADC_BITS];
         s1_ff.row    <= row_sel;
         s1_ff.col    <= col_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff <= num_x[ADC_BITS] ? ADC_BITS'(-num_x) : num_x[ADC_BITS-1:0];
         dx_ff <= den_x[ADC_BITS] ? ADC_BITS'(-den_x) : den_x[ADC_BITS-1:0];
         ny_ff <= num_y[ADC_BITS] ? ADC_BITS'(-num_y) : num_y[ADC_BITS-1:0];
         dy_ff <= den_y[ADC_BITS] ? ADC_BITS'(-den_y) : den_y[ADC_BITS-1:0];
      end
   end

   logic [QUOT_BITS-1:0] quot_x, quot_y;

   tbc_divider u_div_x (
      .clock    (clock),
      .enable   (advance),
      .num_in   (nx_ff),
      .den_in   (dx_ff),
      .quot_out (quot_x)
   );

   tbc_divider u_div_y (
      .clock    (clock),
      .enable   (advance),
      .num_in   (ny_ff),
      .den_in   (dy_ff),
      .quot_out (quot_y)
   );

   side_type side_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) side_ff[i] <= '0;
      end else if (advance) begin
         side_ff[0] <= s1_ff;
         for (int i = 1; i < DIV_STAGES; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // Target coordinates of the chosen cell, then u times the span.
   side_type            sd;
   logic [TW-1:0]       half_w, half_h, far_w, far_h;
   logic [TW-1:0]       tx0, tx1, ty0, ty1, span_x, span_y, mag_x, mag_y;
   blend_type           bx_in, by_in, bx_ff, by_ff;

   always_comb begin
      sd     = side_ff[DIV_STAGES-1];
      half_w = TW'(width_ff >> 1);
      half_h = TW'(height_ff >> 1);
      far_w  = TW'(width_ff) - TW'(EDGE_INSET);
      far_h  = TW'(height_ff) - TW'(EDGE_INSET);
      tx0    = sd.col ? half_w : TW'(EDGE_INSET);
      tx1    = sd.col ? far_w : half_w;
      ty0    = sd.row ? half_h : TW'(EDGE_INSET);
      ty1    = sd.row ? far_h : half_h;
      span_x = tx1 - tx0;
      span_y = ty1 - ty0;
      mag_x  = span_x[TW-1] ? -span_x : span_x;
      mag_y  = span_y[TW-1] ? -span_y : span_y;
      bx_in.valid = sd.valid;
      bx_in.ok    = sd.ok;
      bx_in.neg   = sd.sign_x ^ span_x[TW-1];
      bx_in.prod  = PW'(quot_x) * PW'(mag_x);
      bx_in.base  = tx0;
      by_in.valid = sd.valid;
      by_in.ok    = sd.ok;
      by_in.neg   = sd.sign_y ^ span_y[TW-1];
      by_in.prod  = PW'(quot_y) * PW'(mag_y);
      by_in.base  = ty0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bx_ff <= '0;
         by_ff <= '0;
      end else if (advance) begin
         bx_ff <= bx_in;
         by_ff <= by_in;
      end
   end

   function automatic logic [COORD_BITS-1:0] finish(input blend_type b,
                                                    input logic [COORD_BITS-1:0] cap);
      logic signed [SW-1:0] sum;
      logic [SW-1:0]        q;
      sum = ($signed(SW'($signed(b.base))) <<< FRACTION_BITS)
          + (b.neg ? -$signed(SW'(b.prod)) : $signed(SW'(b.prod)));
      q   = SW'(sum) >> (FRACTION_BITS - 4);
      if (!b.ok || sum < 0) return '0;
      if (q > SW'(cap)) return cap;
      return q[COORD_BITS-1:0];
   endfunction

   logic                  rsp_valid_ff, rsp_ok_ff;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= bx_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ok_ff <= bx_ff.ok;
         rsp_x_ff  <= finish(bx_ff, MAX_X_SIXTEENTHS);
         rsp_y_ff  <= finish(by_ff, MAX_Y_SIXTEENTHS);
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_ok                  = rsp_ok_ff;
   assign rsp_screen_x_sixteenths = rsp_x_ff;
   assign rsp_screen_y_sixteenths = rsp_y_ff;

`ifndef SYNTHESIS
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no response waiting");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_screen_x_sixteenths == '0 && rsp_screen_y_sixteenths == '0)
      else $error("degenerate cell gave non-zero coordinates");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_screen_x_sixteenths <= MAX_X_SIXTEENTHS
                    && rsp_screen_y_sixteenths <= MAX_Y_SIXTEENTHS)
      else $error("coordinate above clamp");

   a_record_no_response: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACTION_RECORD |=> !s1_ff.valid)
      else $error("record request entered the pipeline as valid");
`endif

endmodule

// ----- bench/touch_calibration_checker.sv -----
// Watches the calibrator channels, predicts each mapped point and compares the responses.
module touch_calibration_checker
   import tbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_action,
   input  logic [NODE_BITS-1:0]  req_node_index,
   input  logic [ADC_BITS-1:0]   req_raw_x,
   input  logic [ADC_BITS-1:0]   req_raw_y,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_ok,
   input  logic [COORD_BITS-1:0] rsp_screen_x_sixteenths,
   input  logic [COORD_BITS-1:0] rsp_screen_y_sixteenths,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [SIZE_BITS-1:0]  csr_data,
   output int                    mismatches,
   output int                    points_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                  ok;
      logic [COORD_BITS-1:0] sx;
      logic [COORD_BITS-1:0] sy;
   } screen_point_type;

   screen_point_type expected_points[$];
   int node_x[NODE_COUNT];
   int node_y[NODE_COUNT];
   int width_px;
   int height_px;

   assign points_pending = expected_points.size();

   function automatic int largest(int a, int b, int c);
      int m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

   function automatic bit between(int p, int e0, int e1);
      return (p >= e0 && p <= e1) || (p <= e0 && p >= e1);
   endfunction

   function automatic longint fraction_of(int num, int den);
      longint n, d, q;
      n = (num < 0) ? -longint'(num) : longint'(num);
      d = (den < 0) ? -longint'(den) : longint'(den);
      q = (n <<< FRACTION_BITS) / d;
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic longint scaled_product(longint a, longint b);
      logic [63:0]  ma, mb, r;
      logic [127:0] p;
      ma = (a < 0) ? 64'(-a) : 64'(a);
      mb = (b < 0) ? 64'(-b) : 64'(b);
      p = {64'd0, ma} * {64'd0, mb};
      if (p[127:80] != 0) begin
         r = 64'd1 << 60;
      end else begin
         r = p[79:16];
         if (r > (64'd1 << 60)) r = 64'd1 << 60;
      end
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [COORD_BITS-1:0] blended(longint u, longint v, int s00,
                                                     int s10, int s01, int s11,
                                                     logic [COORD_BITS-1:0] cap);
      longint top, bottom, mix, q;
      top = longint'(s00) * (64'sd1 <<< FRACTION_BITS) + u * longint'(s10 - s00);
      bottom = longint'(s01) * (64'sd1 <<< FRACTION_BITS) + u * longint'(s11 - s01);
      mix = top + scaled_product(v, bottom - top);
      if (mix < 0) return '0;
      q = mix >>> (FRACTION_BITS - 4);
      return (q > longint'(cap)) ? cap : COORD_BITS'(q);
   endfunction

   function automatic screen_point_type mapped_point(int px, int py);
      screen_point_type pt;
      int row, col, base, dx, dy;
      int tx[3];
      int ty[3];
      longint u, v;
      row = -1;
      col = -1;
      if (py < largest(node_y[0], node_y[1], node_y[2])) row = 0;
      else if (between(py, node_y[0], node_y[3])) row = 0;
      else if (between(py, node_y[3], node_y[6])) row = 1;
      if (row < 0) row = 1;
      if (px < largest(node_x[0], node_x[3], node_x[6])) col = 0;
      else if (between(px, node_x[0], node_x[1])) col = 0;
      else if (between(px, node_x[1], node_x[2])) col = 1;
      if (col < 0) col = 1;
      base = row * 3 + col;
      dx = node_x[base + 1] - node_x[base];
      dy = node_y[base + 3] - node_y[base];
      pt = '0;
      if (dx == 0 || dy == 0) return pt;
      u = fraction_of(px - node_x[base], dx);
      v = fraction_of(py - node_y[base], dy);
      tx = '{EDGE_INSET, width_px / 2, width_px - EDGE_INSET};
      ty = '{EDGE_INSET, height_px / 2, height_px - EDGE_INSET};
      pt.ok = 1'b1;
      pt.sx = blended(u, v, tx[col], tx[col + 1], tx[col], tx[col + 1], MAX_X_SIXTEENTHS);
      pt.sy = blended(u, v, ty[row], ty[row], ty[row + 1], ty[row + 1], MAX_Y_SIXTEENTHS);
      return pt;
   endfunction

   initial begin
      mismatches = 0;
      node_x = '{default: 0};
      node_y = '{default: 0};
      width_px = RESET_WIDTH;
      height_px = RESET_HEIGHT;
   end

   always @(posedge clock) begin
      screen_point_type want;
      if (reset) begin
         width_px = RESET_WIDTH;
         height_px = RESET_HEIGHT;
         expected_points.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_SCREEN_WIDTH) width_px = csr_data;
            else height_px = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected response ok=%0d x=%0d y=%0d", rsp_ok,
                           rsp_screen_x_sixteenths, rsp_screen_y_sixteenths);
            end else begin
               want = expected_points.pop_front();
               if (want.ok !== rsp_ok || want.sx !== rsp_screen_x_sixteenths ||
                   want.sy !== rsp_screen_y_sixteenths) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected ok=%0d x=%0d y=%0d, got ok=%0d x=%0d y=%0d",
                              want.ok, want.sx, want.sy, rsp_ok,
                              rsp_screen_x_sixteenths, rsp_screen_y_sixteenths);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACTION_MAP) begin
               expected_points.push_back(mapped_point(req_raw_x, req_raw_y));
            end else if (req_node_index < NODE_COUNT) begin
               node_x[req_node_index] = req_raw_x;
               node_y[req_node_index] = req_raw_y;
            end
         end
      end
   end
endmodule

// ----- bench/tb.sv -----
// Testbench top: clock, reset, request and register stimulus, and the verdict.
module tb;
   import tbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_action;
   logic [NODE_BITS-1:0]  req_node_index;
   logic [ADC_BITS-1:0]   req_raw_x;
   logic [ADC_BITS-1:0]   req_raw_y;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_ok;
   logic [COORD_BITS-1:0] rsp_screen_x_sixteenths;
   logic [COORD_BITS-1:0] rsp_screen_y_sixteenths;
   logic                  csr_write;
   logic                  csr_index;
   logic [SIZE_BITS-1:0]  csr_data;
   int                    mismatches;
   int                    points_pending;

   bit calm;
   bit rsp_taken;
   int stall_left;
   int grid_x[3];
   int grid_y[3];

   touch_bilinear_calibrator_core dut (.*);
   touch_calibration_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) rsp_taken <= rsp_valid && !rsp_stall;

   always @(negedge clock) begin
      if (rsp_taken) stall_left = calm ? 0 : $urandom_range(0, 15);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(logic action, int index, int x, int y);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action <= action;
      req_node_index <= NODE_BITS'(index);
      req_raw_x <= ADC_BITS'(x);
      req_raw_y <= ADC_BITS'(y);
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_screen(int w, int h);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (points_pending == 0);
      repeat (15) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_data <= SIZE_BITS'(w);
      @(negedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_data <= SIZE_BITS'(h);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic record_grid();
      int jx, jy;
      grid_x[0] = $urandom_range(0, 1500);
      grid_x[1] = grid_x[0] + $urandom_range(0, 1300);
      grid_x[2] = grid_x[1] + $urandom_range(0, 1240);
      grid_y[0] = $urandom_range(0, 1500);
      grid_y[1] = grid_y[0] + $urandom_range(0, 1300);
      grid_y[2] = grid_y[1] + $urandom_range(0, 1240);
      for (int n = 0; n < NODE_COUNT; n++) begin
         jx = grid_x[n % 3] + $urandom_range(0, 50);
         jy = grid_y[n / 3] + $urandom_range(0, 50);
         send_request(ACTION_RECORD, n, jx, jy);
      end
   endtask

   initial begin
      int pick, w, h;
      calm = 1'b0;
      stall_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACTION_RECORD;
      req_node_index = '0;
      req_raw_x = '0;
      req_raw_y = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_SCREEN_WIDTH;
      csr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The full-span grid, ignored node numbers, corner points and a collapsed cell.
      for (int n = 0; n < NODE_COUNT; n++)
         send_request(ACTION_RECORD, n, (n % 3) * 2047 + (n % 3) / 2,
                      (n / 3) * 2047 + (n / 3) / 2);
      send_request(ACTION_RECORD, 9, 4095, 4095);
      send_request(ACTION_RECORD, 15, 1234, 3210);
      send_request(ACTION_MAP, 0, 0, 0);
      send_request(ACTION_MAP, 0, 4095, 4095);
      send_request(ACTION_MAP, 0, 2047, 2047);
      send_request(ACTION_MAP, 0, 3000, 1000);
      send_request(ACTION_RECORD, 1, 0, 0);
      send_request(ACTION_MAP, 0, 100, 100);
      send_request(ACTION_MAP, 0, 2500, 4000);
      send_request(ACTION_RECORD, 3, 4095, 1000);
      send_request(ACTION_MAP, 1, 4000, 1500);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin w = 32; h = 32; end
            1: begin w = 1023; h = 1023; end
            2: begin w = 32; h = 1023; end
            3: begin w = 1023; h = 32; end
            4: begin w = 320; h = 480; end
            default: begin w = $urandom_range(32, 1023); h = $urandom_range(32, 1023); end
         endcase
         set_screen(w, h);
         calm = (phase % 3 == 2);
         record_grid();
         for (int k = 0; k < 180; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               record_grid();
            end else if (pick < 60) begin
               send_request(ACTION_MAP, $urandom_range(0, 15),
                            $urandom_range(grid_x[0], grid_x[2] + 50),
                            $urandom_range(grid_y[0], grid_y[2] + 50));
            end else if (pick < 85) begin
               send_request(ACTION_MAP, $urandom_range(0, 15), $urandom_range(0, 4095),
                            $urandom_range(0, 4095));
            end else if (pick < 95) begin
               send_request(ACTION_RECORD, $urandom_range(0, 8), $urandom_range(0, 4095),
                            $urandom_range(0, 4095));
            end else begin
               send_request(ACTION_RECORD, $urandom_range(9, 15), $urandom_range(0, 4095),
                            $urandom_range(0, 4095));
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      calm = 1'b0;
      wait (points_pending == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
